### rtl/mpd_pkg.sv
// Shared types and constants for the Mahalanobis pair distance unit.
`default_nettype none
package mpd_pkg;

  localparam int DEF_ROWS = 1024;
  localparam int DEF_VARS = 16;

  localparam int CMD_W  = 2;
  localparam int ROW_W  = 10;
  localparam int VAR_W  = 4;
  localparam int DATA_W = 32;
  localparam int DIST_W = 32;
  localparam int CFG_W  = 5;
  localparam int DIFF_W = DATA_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int FRAC_SHIFT = 24;
  localparam int SQ_IN_W = 64;
  localparam int SQ_STEPS = 32;

  localparam logic [CFG_W-1:0] VIU_RESET = CFG_W'(16);

  localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RMOD,
    ST_DLOAD,
    ST_MAC_ISSUE,
    ST_MAC_DRAIN,
    ST_TERM_LO,
    ST_TERM_HI,
    ST_TERM_ADD,
    ST_RESULT,
    ST_SQRT
  } state_t;

endpackage
`default_nettype wire

### rtl/mpd_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic [AW-1:0]          raddr,
  output logic      [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/mpd_isqrt.sv
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module mpd_isqrt
  import mpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [SQ_IN_W-1:0] x,
  output logic                    done,
  output logic [DIST_W-1:0]       root
);
  localparam int CNT_W = $clog2(SQ_STEPS);

  logic [SQ_IN_W-1:0] rem;
  logic [SQ_IN_W-1:0] res;
  logic [SQ_IN_W-1:0] bitv;
  logic [SQ_IN_W-1:0] trial;
  logic [CNT_W-1:0]   cnt;
  logic               running;

  assign trial = res + bitv;
  assign root  = res[DIST_W-1:0];

  // control: run for a fixed number of steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(SQ_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath: one restoring step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= x;
      res  <= '0;
      bitv <= SQ_IN_W'(1) << (SQ_IN_W - 2);
    end else if (running) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule
`default_nettype wire

### rtl/mahalanobis_pair_distance_unit.sv
// Top level: row and weight stores, multiply-accumulate sequencer, square root.
// A query runs its products on the single multiplier, which walks the weight store
// one entry per cycle while in the issue state, and ends with the 32-step root.
// A row index at or above ROWS is reduced by ROWS in the row-modulo state until it
// is in range; writes are done in that state. One item at a time.
// Reset clears control and sets vars_in_use to 16; the stores are not cleared.
`default_nettype none
module mahalanobis_pair_distance_unit
  import mpd_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int VARS = DEF_VARS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [CMD_W-1:0]          cmd,
  input  wire logic [ROW_W-1:0]          row_a,
  input  wire logic [ROW_W-1:0]          row_b,
  input  wire logic [VAR_W-1:0]          var_i,
  input  wire logic [VAR_W-1:0]          var_j,
  input  wire logic signed [DATA_W-1:0]  value,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_W-1:0]          cfg_data,
  output logic                           done,
  output logic [DIST_W-1:0]              distance,
  output logic                           not_positive
);
  localparam int DAW = $clog2(ROWS * VARS);
  localparam int VW  = (VARS > 1) ? $clog2(VARS) : 1;
  localparam int WAW = (VARS > 1) ? $clog2(VARS * VARS) : 1;
  localparam int CW  = $clog2(VARS + 1);
  localparam int SW  = CW + 1;
  localparam int IW  = PROD_W - FRAC_SHIFT + $clog2(VARS);
  localparam int HW  = IW - FRAC_SHIFT;
  localparam int ACW = IW + DIFF_W + $clog2(VARS);

  state_t state, state_next;

  logic [CFG_W-1:0]   vars_in_use;
  logic [CMD_W-1:0]   cmd_q;
  logic [ROW_W-1:0]   ra_q, rb_q;
  logic [VAR_W-1:0]   vi_q, vj_q;
  logic [DATA_W-1:0]  val_q;
  logic [CW-1:0]      n_q, kc, jc;
  logic [SW-1:0]      sc;
  logic               need_mod;

  logic               ld_v, ld_ph;
  logic [VW-1:0]      ld_k;
  logic [DATA_W-1:0]  a_hold;

  logic               m1_v, m1_first, m1_last, m1_isj;
  logic               m2_v, m2_first;
  logic signed [DIFF_W-1:0] dj;
  logic signed [PROD_W-1:0] prod;
  logic signed [IW-1:0]     inner;
  logic signed [HW-1:0]     inner_hi;
  logic signed [ACW-1:0]    acc;
  logic signed [DIFF_W-1:0] mul_a, mul_b;

  logic               x_we;
  logic [DAW-1:0]     x_waddr, x_raddr;
  logic [DATA_W-1:0]  x_rdata;
  logic               w_we;
  logic [WAW-1:0]     w_waddr, w_raddr;
  logic [DATA_W-1:0]  w_rdata;
  logic               d_we;
  logic [VW-1:0]      d_waddr, d_raddr;
  logic [DIFF_W-1:0]  d_wdata, d_rdata;

  logic               ld_issue, mac_issue;
  logic               acc_neg, acc_sat;
  logic               sq_start, sq_done;
  logic [DIST_W-1:0]  sq_root;
  logic               res_fire, res_np;
  logic [DIST_W-1:0]  res_dist;
  logic [ROW_W-1:0]   ld_row;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign need_mod  = (32'(ra_q) >= ROWS) || (32'(rb_q) >= ROWS);
  assign inner_hi  = inner[IW-1:FRAC_SHIFT];
  assign acc_neg   = acc[ACW-1];
  assign acc_sat   = |acc[ACW-2:SQ_IN_W];
  assign ld_issue  = (state == ST_DLOAD) && (sc < SW'({n_q, 1'b0}));
  assign mac_issue = (state == ST_MAC_ISSUE);
  assign ld_row    = sc[0] ? rb_q : ra_q;

  // stores
  mpd_ram #(.WIDTH(DATA_W), .DEPTH(ROWS * VARS)) u_data_ram (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(val_q),
    .raddr(x_raddr), .rdata(x_rdata)
  );

  mpd_ram #(.WIDTH(DATA_W), .DEPTH(VARS * VARS)) u_weight_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(val_q),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  mpd_ram #(.WIDTH(DIFF_W), .DEPTH(VARS)) u_diff_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  mpd_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .x(acc[SQ_IN_W-1:0]),
    .done(sq_done), .root(sq_root)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_RMOD;
      end
      ST_RMOD: begin
        if (!need_mod) begin
          if (cmd_q == CMD_QUERY) begin
            state_next = (n_q == '0) ? ST_RESULT : ST_DLOAD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DLOAD: begin
        if (!ld_issue && !ld_v) state_next = ST_MAC_ISSUE;
      end
      ST_MAC_ISSUE: begin
        if (kc == n_q - CW'(1)) state_next = ST_MAC_DRAIN;
      end
      ST_MAC_DRAIN: begin
        if (!m1_v && !m2_v) state_next = ST_TERM_LO;
      end
      ST_TERM_LO:  state_next = ST_TERM_HI;
      ST_TERM_HI:  state_next = ST_TERM_ADD;
      ST_TERM_ADD: begin
        state_next = (jc == n_q - CW'(1)) ? ST_RESULT : ST_MAC_ISSUE;
      end
      ST_RESULT: begin
        state_next = (acc_neg || acc_sat) ? ST_IDLE : ST_SQRT;
      end
      ST_SQRT: begin
        if (sq_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // store accesses, multiplier operands and result
  always_comb begin
    x_we     = 1'b0;
    x_waddr  = DAW'(32'(ra_q) * VARS + 32'(vi_q));
    x_raddr  = DAW'(32'(ld_row) * VARS + 32'(sc[SW-1:1]));
    w_we     = 1'b0;
    w_waddr  = WAW'(32'(vi_q) * VARS + 32'(vj_q));
    w_raddr  = WAW'(32'(kc) * VARS + 32'(jc));
    d_we     = ld_v && ld_ph;
    d_waddr  = ld_k;
    d_wdata  = DIFF_W'(signed'(a_hold)) - DIFF_W'(signed'(x_rdata));
    d_raddr  = VW'(kc);
    mul_a    = signed'(d_rdata);
    mul_b    = DIFF_W'(signed'(w_rdata));
    sq_start = 1'b0;
    res_fire = 1'b0;
    res_np   = 1'b0;
    res_dist = '0;
    unique case (state)
      ST_RMOD: begin
        if (!need_mod && (32'(vi_q) < VARS)) begin
          if (cmd_q == CMD_WEIGHT && (32'(vj_q) < VARS)) w_we = 1'b1;
          if (cmd_q == CMD_DATA) x_we = 1'b1;
        end
      end
      ST_TERM_LO: begin
        mul_a = dj;
        mul_b = DIFF_W'({1'b0, inner[FRAC_SHIFT-1:0]});
      end
      ST_TERM_HI: begin
        mul_a = dj;
        mul_b = DIFF_W'(inner_hi);
      end
      ST_RESULT: begin
        if (acc_neg) begin
          res_fire = 1'b1;
          res_np   = 1'b1;
        end else if (acc_sat) begin
          res_fire = 1'b1;
          res_dist = '1;
        end else begin
          sq_start = 1'b1;
        end
      end
      ST_SQRT: begin
        res_fire = sq_done;
        res_dist = sq_root;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      vars_in_use <= VIU_RESET;
      ld_v        <= 1'b0;
      m1_v        <= 1'b0;
      m2_v        <= 1'b0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) vars_in_use <= cfg_data;
      ld_v <= ld_issue;
      m1_v <= mac_issue;
      m2_v <= m1_v;
      done <= res_fire;
    end
  end

  // latch the request and walk the counters
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cmd_q <= cmd;
      ra_q  <= row_a;
      rb_q  <= row_b;
      vi_q  <= var_i;
      vj_q  <= var_j;
      val_q <= value;
      n_q   <= CW'((32'(vars_in_use) > VARS) ? VARS : 32'(vars_in_use));
      kc    <= '0;
      jc    <= '0;
      sc    <= '0;
    end
    if (state == ST_RMOD) begin
      if (32'(ra_q) >= ROWS) ra_q <= ra_q - ROW_W'(ROWS);
      if (32'(rb_q) >= ROWS) rb_q <= rb_q - ROW_W'(ROWS);
    end
    if (ld_issue) sc <= sc + SW'(1);
    if (mac_issue) begin
      kc <= (kc == n_q - CW'(1)) ? '0 : kc + CW'(1);
    end
    if (state == ST_TERM_ADD) jc <= jc + CW'(1);
  end

  // datapath: row differences, inner sums and the quadratic form
  always_ff @(posedge clk) begin
    ld_ph    <= sc[0];
    ld_k     <= VW'(sc[SW-1:1]);
    m1_first <= (kc == '0);
    m1_last  <= (kc == n_q - CW'(1));
    m1_isj   <= (kc == jc);
    m2_first <= m1_first;
    prod     <= mul_a * mul_b;
    if (ld_v && !ld_ph) a_hold <= x_rdata;
    if (m1_v && m1_isj) dj <= signed'(d_rdata);
    if (m2_v) inner <= (m2_first ? IW'(0) : inner) + IW'(prod >>> FRAC_SHIFT);
    if (state == ST_IDLE && start) acc <= '0;
    if (state == ST_TERM_HI) acc <= acc + ACW'(prod);
    if (state == ST_TERM_ADD) acc <= acc + (ACW'(prod) <<< FRAC_SHIFT);
    if (res_fire) begin
      distance     <= res_dist;
      not_positive <= res_np;
    end
  end

`ifndef SYNTHESIS
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_RESULT || $past(state) == ST_SQRT))
    else $error("result strobe outside result states");

  a_neg_zero: assert property (@(posedge clk) disable iff (rst)
    (done && not_positive) |-> (distance == '0))
    else $error("negative form with non-zero distance");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but unit not busy");

  a_mac_last: assert property (@(posedge clk) disable iff (rst)
    (m1_v && m1_last) |=> (state == ST_MAC_DRAIN))
    else $error("last product seen outside drain");
`endif

endmodule
`default_nettype wire

### test/mahalanobis_pair_distance_unit_test.sv
// Testbench for the Mahalanobis pair distance unit: self-predicting, random with idling.
`timescale 1ns / 100ps
module mahalanobis_pair_distance_unit_test;
  import mpd_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int NROWS = 1024;
  localparam int NVARS = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [CFG_W-1:0] VIU_NONE = 5'd0;
  localparam logic [CFG_W-1:0] VIU_ONE  = 5'd1;
  localparam logic [CFG_W-1:0] VIU_FULL = 5'd16;
  localparam logic [CFG_W-1:0] VIU_MAX  = 5'd31;

  typedef logic signed [127:0] acc_t;
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              not_positive;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] cmd = '0;
  logic [ROW_W-1:0] row_a = '0;
  logic [ROW_W-1:0] row_b = '0;
  logic [VAR_W-1:0] var_i = '0;
  logic [VAR_W-1:0] var_j = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic done;
  logic [DIST_W-1:0] distance;
  logic not_positive;

  // Shadow copies of the stores and the register
  logic [31:0] row_mem [NROWS*NVARS];
  logic [31:0] weight_mem [NVARS*NVARS];
  logic [15:0] row_mask [NROWS];
  int full_rows [$];
  logic [CFG_W-1:0] viu_shadow = VIU_RESET;

  answer_t pending_answers [$];
  int faults = 0;
  int cycles = 0;
  bit quiet_sender = 1'b0;

  mahalanobis_pair_distance_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .row_a(row_a),
    .row_b(row_b), .var_i(var_i), .var_j(var_j), .value(value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .distance(distance), .not_positive(not_positive)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [31:0] root64(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  // Quadratic form of the row difference, then the saturated root
  function automatic answer_t pair_distance(int ra, int rb);
    acc_t diff [NVARS];
    acc_t inner;
    acc_t q;
    acc_t w;
    answer_t ans;
    int n;
    n = (viu_shadow > VIU_FULL) ? NVARS : int'(viu_shadow);
    q = '0;
    for (int k = 0; k < n; k++) begin
      diff[k] = acc_t'($signed(row_mem[ra*NVARS+k])) - acc_t'($signed(row_mem[rb*NVARS+k]));
    end
    for (int j = 0; j < n; j++) begin
      inner = '0;
      for (int k = 0; k < n; k++) begin
        w = acc_t'($signed(weight_mem[k*NVARS+j]));
        inner = inner + ((diff[k] * w) >>> FRAC_SHIFT);
      end
      q = q + inner * diff[j];
    end
    ans.not_positive = q[127];
    if (q[127]) ans.distance = '0;
    else if (q[127:64] != 0) ans.distance = '1;
    else ans.distance = root64(q[63:0]);
    return ans;
  endfunction

  function automatic int pick_gap();
    if (quiet_sender || $urandom_range(0, 99) >= 32) return 0;
    return $urandom_range(1, 5);
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  // Send one request; start stays high if the next follows straight on
  task automatic send_request(logic [CMD_W-1:0] c, int ra, int rb, int vi, int vj,
                              logic [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    row_a <= ROW_W'(ra);
    row_b <= ROW_W'(rb);
    var_i <= VAR_W'(vi);
    var_j <= VAR_W'(vj);
    value <= v;
    do @(posedge clk); while (busy);
    // Request accepted: update shadow state and predict
    case (c)
      CMD_WEIGHT: weight_mem[vi*NVARS+vj] = v;
      CMD_DATA: begin
        row_mem[ra*NVARS+vi] = v;
        row_mask[ra][vi] = 1'b1;
        if (row_mask[ra] == 16'hFFFF && !(ra inside {full_rows})) full_rows.push_back(ra);
      end
      CMD_QUERY: pending_answers.push_back(pair_distance(ra, rb));
      default: ;
    endcase
  endtask

  task automatic fill_row(int r, bit extreme);
    for (int v = 0; v < NVARS; v++) begin
      send_request(CMD_DATA, r, $urandom_range(0, NROWS-1), v, $urandom_range(0, 15),
                   extreme ? ((v % 2) ? 32'h7FFF_FFFF : 32'h8000_0000) : pick_data());
    end
  endtask

  // mode 0: near identity, 1: full range, 2: negative diagonal
  task automatic load_weights(int mode);
    logic [31:0] w;
    for (int i = 0; i < NVARS; i++) begin
      for (int j = 0; j < NVARS; j++) begin
        case (mode)
          0: w = (i == j) ? 32'h0100_0000 + $urandom_range(0, 32'h00FF_FFFF)
                          : 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
          1: w = $urandom;
          default: w = (i == j) ? 32'hFF00_0000 : 32'h0;
        endcase
        send_request(CMD_WEIGHT, $urandom_range(0, NROWS-1), $urandom_range(0, NROWS-1),
                     i, j, w);
      end
    end
  endtask

  task automatic query_random();
    send_request(CMD_QUERY, full_rows[$urandom_range(0, full_rows.size()-1)],
                 full_rows[$urandom_range(0, full_rows.size()-1)],
                 $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
  endtask

  // Write the register once the unit has drained
  task automatic set_vars_in_use(logic [CFG_W-1:0] n);
    @(posedge clk);
    start <= 1'b0;
    wait (pending_answers.size() == 0);
    @(posedge clk);
    while (busy) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    viu_shadow = n;
  endtask

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: distance %0h not_positive %0b", distance, not_positive);
        faults++;
      end else begin
        if (distance !== pending_answers[0].distance) begin
          $error("distance: expected %0h, got %0h", pending_answers[0].distance, distance);
          faults++;
        end
        if (not_positive !== pending_answers[0].not_positive) begin
          $error("not_positive: expected %0b, got %0b",
                 pending_answers[0].not_positive, not_positive);
          faults++;
        end
        void'(pending_answers.pop_front());
      end
    end
  end

  task automatic test_loading();
    load_weights(0);
    fill_row(0, 1'b0);
    fill_row(NROWS-1, 1'b0);
    for (int r = 0; r < 10; r++) fill_row($urandom_range(1, NROWS-2), 1'b0);
  endtask

  task automatic test_directed();
    fill_row(512, 1'b1);
    fill_row(511, 1'b1);
    send_request(CMD_QUERY, 0, NROWS-1, 0, 0, 0);
    send_request(CMD_QUERY, 512, 512, 15, 15, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, 512, 511, 0, 0, 0);
    // ignored command and out-of-use fields
    send_request(CMD_UNUSED, 512, 511, 15, 15, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, NROWS-1, 0, 0, 0, 0);
    set_vars_in_use(VIU_NONE);
    send_request(CMD_QUERY, 512, 511, 0, 0, 0);
    set_vars_in_use(VIU_ONE);
    send_request(CMD_QUERY, 512, 511, 0, 0, 0);
    send_request(CMD_QUERY, 0, NROWS-1, 0, 0, 0);
    set_vars_in_use(VIU_MAX);
    send_request(CMD_QUERY, 512, 0, 0, 0, 0);
  endtask

  task automatic test_negative_form();
    load_weights(2);
    set_vars_in_use(VIU_FULL);
    for (int i = 0; i < 4; i++) query_random();
    send_request(CMD_QUERY, 512, 512, 0, 0, 0);
  endtask

  task automatic test_random_mix(int items);
    int pick;
    for (int i = 0; i < items; i++) begin
      quiet_sender = (i >= items / 3) && (i < items / 2);
      if (i % 100 == 50) set_vars_in_use(5'($urandom_range(0, 31)));
      if (i == items / 4) load_weights(1);
      if (i == items * 3 / 4) load_weights(0);
      pick = $urandom_range(0, 99);
      if (pick < 55) query_random();
      else if (pick < 75)
        send_request(CMD_DATA, $urandom_range(0, NROWS-1), $urandom_range(0, NROWS-1),
                     $urandom_range(0, 15), $urandom_range(0, 15), pick_data());
      else if (pick < 80) fill_row($urandom_range(0, NROWS-1), 1'b0);
      else if (pick < 95)
        send_request(CMD_WEIGHT, $urandom_range(0, NROWS-1), $urandom_range(0, NROWS-1),
                     $urandom_range(0, 15), $urandom_range(0, 15),
                     ($urandom_range(0, 3) == 0) ? $urandom : pick_data());
      else
        send_request(CMD_UNUSED, $urandom_range(0, NROWS-1), $urandom_range(0, NROWS-1),
                     $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
    end
    quiet_sender = 1'b0;
  endtask

  initial begin
    for (int r = 0; r < NROWS; r++) row_mask[r] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_loading();
    test_directed();
    test_negative_form();
    load_weights(0);
    test_random_mix(400);
    @(posedge clk);
    start <= 1'b0;
    wait (pending_answers.size() == 0);
    repeat (50) @(posedge clk);
    if (faults == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
